@@ rtl/tirt_pkg.sv @@
// shared constants and codes for the transaction id remap table
`default_nettype none
package tirt_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int CTLR_COUNT      = 8;
  localparam int XID_W           = 32;
  localparam int CTLR_W          = 3;
  localparam int PERIOD_W        = 16;
  localparam int ACT_W           = 3;
  localparam int OP_W            = 2;
  localparam int IN_TDATA_W      = 40;
  localparam int IN_TUSER_W      = 4;
  localparam int OUT_TDATA_W     = 40;
  localparam int OUT_TUSER_W     = 3;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5;

  localparam logic [OP_W-1:0] OP_CTLR   = 2'd0;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_DISC   = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TO_SWITCH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TO_CTLR   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ECHO      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BARRIER   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FULL      = 3'd5;

endpackage
`default_nettype wire

@@ rtl/tirt_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module tirt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tirt_xid_mod.sv @@
// transaction id modulo table depth, mask or one bit per cycle
`default_nettype none
module tirt_xid_mod #(
  parameter int DEPTH = tirt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tirt_pkg::XID_W-1:0]    value,
  output logic                               done,
  output logic      [$clog2(DEPTH)-1:0]      rem
);

  localparam int  AW   = $clog2(DEPTH);
  localparam int  CNTW = $clog2(tirt_pkg::XID_W);
  localparam bit  POW2 = (DEPTH & (DEPTH - 1)) == 0;
  localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic [tirt_pkg::XID_W-1:0] val_r, val_nxt;
  logic [AW-1:0]              rem_r, rem_nxt;
  logic [AW:0]                sh;
  logic [AW:0]                red;

  always_comb begin
    sh       = {rem_r, val_r[tirt_pkg::XID_W-1]};
    red      = (sh >= DEPTH_V) ? sh - DEPTH_V : sh;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    if (start) begin
      if (POW2) begin
        rem_nxt  = value[AW-1:0];
        done_nxt = 1'b1;
      end else begin
        val_nxt  = value;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // restoring reduction, msb first
      rem_nxt = red[AW-1:0];
      val_nxt = {val_r[tirt_pkg::XID_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(tirt_pkg::XID_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r <= val_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ rtl/transaction_id_remap_table.sv @@
// top level of the transaction id remap table
//
// Remaps transaction ids between several controllers and one switch. One input
// transaction gives exactly one result transaction; items are handled one at a
// time, and the next one is taken while a finished result still waits at the
// output. All entries live in one ram with a registered read, read,
// checked and written back by a sequencer. An echo is answered from the
// input alone, a controller request, tick or barrier request from a table
// lookup, and a switch reply after the id modulo unit, which masks the id
// when TABLE_DEPTH is a power of two and otherwise works one bit per cycle.
// A barrier reply or a controller disconnect walks the whole table through
// the ram read port. After reset the table is cleared entry by entry,
// during which no input is accepted; configuration writes are taken at any time.
`default_nettype none
module transaction_id_remap_table #(
  parameter int TABLE_DEPTH = tirt_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // tuser: opcode[1:0], is_echo[2], is_barrier_reply[3]
  input  wire logic [tirt_pkg::IN_TUSER_W-1:0]      in_tuser,
  // tdata: ctlr_id[2:0], msg_xid[34:3], zero fill
  input  wire logic [tirt_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // tuser: action[2:0]
  output logic      [tirt_pkg::OUT_TUSER_W-1:0]     out_tuser,
  // tdata: out_xid[31:0], dest_ctlr[34:32], zero fill
  output logic      [tirt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic [tirt_pkg::PERIOD_W-1:0]        cfg_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = tirt_pkg::XID_W;
  localparam int KW = tirt_pkg::CTLR_W;

  typedef struct packed {
    logic          valid;
    logic          from_ctlr;
    logic [KW-1:0] ctlr;
    logic [XW-1:0] orig;
    logic [XW-1:0] xid;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_LOOKUP, S_WALK, S_REPLY, S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   walk_cnt_r, walk_cnt_nxt;
  logic                            chk_v_r, chk_v_nxt;
  logic [AW-1:0]                   chk_addr_r, chk_addr_nxt;
  logic [tirt_pkg::OP_W-1:0]       op_r, op_nxt;
  logic                            barrier_r, barrier_nxt;
  logic [KW-1:0]                   ctlr_r, ctlr_nxt;
  logic [XW-1:0]                   xid_r, xid_nxt;
  logic                            alloc_ctlr_r, alloc_ctlr_nxt;
  logic [AW-1:0]                   slot_r, slot_nxt;
  entry_t                          hit_r, hit_nxt;
  logic [XW-1:0]                   mine_r, mine_nxt;
  logic [XW-1:0]                   next_id_r, next_id_nxt;
  logic [AW-1:0]                   next_slot_r, next_slot_nxt;
  logic [CW-1:0]                   live_r, live_nxt;
  logic [tirt_pkg::PERIOD_W-1:0]   ticks_r, ticks_nxt;
  logic [tirt_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [tirt_pkg::ACT_W-1:0]      res_act_r, res_act_nxt;
  logic [XW-1:0]                   res_xid_r, res_xid_nxt;
  logic [KW-1:0]                   res_dst_r, res_dst_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tirt_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [tirt_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [EW-1:0]                   ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [EW-1:0]                   ram_rdata;
  logic                            mod_start;
  logic                            mod_done;
  logic [AW-1:0]                   mod_rem;

  logic [tirt_pkg::OP_W-1:0]       in_op;
  logic                            in_echo;
  logic                            in_barrier;
  logic [KW-1:0]                   in_ctlr;
  logic [XW-1:0]                   in_xid;
  logic                            in_acc;
  logic                            ctlr_ok;

  assign in_op      = in_tuser[1:0];
  assign in_echo    = in_tuser[2];
  assign in_barrier = in_tuser[3];
  assign in_ctlr    = in_tdata[KW-1:0];
  assign in_xid     = in_tdata[KW+XW-1:KW];
  assign in_acc     = in_tvalid && in_tready;
  assign ctlr_ok    = 32'(in_ctlr) < tirt_pkg::CTLR_COUNT;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  tirt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tirt_xid_mod #(
    .DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (xid_nxt),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    entry_t rd;
    entry_t wr;
    logic   drop;
    rd             = entry_t'(ram_rdata);
    wr             = '0;
    drop           = 1'b0;
    state_nxt      = state_r;
    walk_cnt_nxt   = walk_cnt_r;
    chk_v_nxt      = chk_v_r;
    chk_addr_nxt   = chk_addr_r;
    op_nxt         = op_r;
    barrier_nxt    = barrier_r;
    ctlr_nxt       = ctlr_r;
    xid_nxt        = xid_r;
    alloc_ctlr_nxt = alloc_ctlr_r;
    slot_nxt       = slot_r;
    hit_nxt        = hit_r;
    mine_nxt       = mine_r;
    next_id_nxt    = next_id_r;
    next_slot_nxt  = next_slot_r;
    live_nxt       = live_r;
    ticks_nxt      = ticks_r;
    period_nxt     = period_r;
    res_act_nxt    = res_act_r;
    res_xid_nxt    = res_xid_r;
    res_dst_nxt    = res_dst_r;
    out_valid_nxt  = out_valid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    mod_start      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = walk_cnt_r[AW-1:0];
        walk_cnt_nxt = walk_cnt_r + 1'b1;
        if (walk_cnt_r == CW'(TABLE_DEPTH - 1)) begin
          walk_cnt_nxt = '0;
          state_nxt    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_op;
          barrier_nxt = in_barrier;
          ctlr_nxt    = in_ctlr;
          xid_nxt     = in_xid;
          res_act_nxt = tirt_pkg::ACT_NONE;
          res_xid_nxt = '0;
          res_dst_nxt = '0;
          state_nxt   = S_DONE;
          unique case (in_op)
            tirt_pkg::OP_CTLR: begin
              if (ctlr_ok && in_echo) begin
                res_act_nxt = tirt_pkg::ACT_ECHO;
                res_xid_nxt = in_xid;
                res_dst_nxt = in_ctlr;
              end else if (ctlr_ok) begin
                alloc_ctlr_nxt = 1'b1;
                ram_raddr      = next_slot_r;
                state_nxt      = S_LOOKUP;
              end
            end
            tirt_pkg::OP_SWITCH: begin
              if (in_echo) begin
                res_act_nxt = tirt_pkg::ACT_ECHO;
                res_xid_nxt = in_xid;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_REDUCE;
              end
            end
            tirt_pkg::OP_TICK: begin
              if (period_r != '0) begin
                if (ticks_r <= tirt_pkg::PERIOD_W'(1)) begin
                  ticks_nxt = period_r;
                  if (live_r != '0) begin
                    alloc_ctlr_nxt = 1'b0;
                    ram_raddr      = next_slot_r;
                    state_nxt      = S_LOOKUP;
                  end
                end else begin
                  ticks_nxt = ticks_r - 1'b1;
                end
              end
            end
            tirt_pkg::OP_DISC: begin
              if (ctlr_ok) begin
                walk_cnt_nxt = '0;
                chk_v_nxt    = 1'b0;
                state_nxt    = S_WALK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_REDUCE: begin
        ram_raddr = mod_rem;
        if (mod_done) begin
          slot_nxt  = mod_rem;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt   = S_DONE;
        res_act_nxt = tirt_pkg::ACT_NONE;
        res_xid_nxt = '0;
        res_dst_nxt = '0;
        if (op_r == tirt_pkg::OP_SWITCH) begin
          if (rd.valid && (rd.xid == xid_r)) begin
            hit_nxt  = rd;
            mine_nxt = next_id_r - xid_r;
            if (barrier_r) begin
              walk_cnt_nxt = '0;
              chk_v_nxt    = 1'b0;
              state_nxt    = S_WALK;
            end else begin
              state_nxt = S_REPLY;
            end
          end
        end else if (rd.valid) begin
          res_act_nxt = tirt_pkg::ACT_FULL;
          res_xid_nxt = next_id_r;
          res_dst_nxt = alloc_ctlr_r ? ctlr_r : '0;
        end else begin
          wr.valid      = 1'b1;
          wr.from_ctlr  = alloc_ctlr_r;
          wr.ctlr       = alloc_ctlr_r ? ctlr_r : '0;
          wr.orig       = alloc_ctlr_r ? xid_r : '0;
          wr.xid        = next_id_r;
          ram_we        = 1'b1;
          ram_waddr     = next_slot_r;
          ram_wdata     = wr;
          live_nxt      = live_r + 1'b1;
          next_id_nxt   = next_id_r + 1'b1;
          next_slot_nxt = (next_slot_r == AW'(TABLE_DEPTH - 1)) ? '0 : next_slot_r + 1'b1;
          res_act_nxt   = alloc_ctlr_r ? tirt_pkg::ACT_TO_SWITCH : tirt_pkg::ACT_BARRIER;
          res_xid_nxt   = next_id_r;
        end
      end
      S_WALK: begin
        // read one entry per cycle, check and clear the one read the cycle before
        if (walk_cnt_r < CW'(TABLE_DEPTH)) begin
          ram_raddr    = walk_cnt_r[AW-1:0];
          chk_v_nxt    = 1'b1;
          chk_addr_nxt = walk_cnt_r[AW-1:0];
          walk_cnt_nxt = walk_cnt_r + 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (chk_v_r) begin
          if (op_r == tirt_pkg::OP_SWITCH) begin
            drop = rd.valid && ((next_id_r - rd.xid) > mine_r);
          end else begin
            drop = rd.valid && rd.from_ctlr && (rd.ctlr == ctlr_r);
          end
          if (drop) begin
            wr        = rd;
            wr.valid  = 1'b0;
            ram_we    = 1'b1;
            ram_waddr = chk_addr_r;
            ram_wdata = wr;
            if (live_r != '0) begin
              live_nxt = live_r - 1'b1;
            end
          end
        end
        if ((walk_cnt_r == CW'(TABLE_DEPTH)) && !chk_v_r) begin
          if (op_r == tirt_pkg::OP_SWITCH) begin
            state_nxt = S_REPLY;
          end else begin
            res_act_nxt = tirt_pkg::ACT_NONE;
            res_xid_nxt = '0;
            res_dst_nxt = '0;
            state_nxt   = S_DONE;
          end
        end
      end
      S_REPLY: begin
        state_nxt = S_DONE;
        if (hit_r.from_ctlr) begin
          res_act_nxt = tirt_pkg::ACT_TO_CTLR;
          res_xid_nxt = hit_r.orig;
          res_dst_nxt = hit_r.ctlr;
        end else begin
          // matched barrier entry leaves the table
          ram_we      = 1'b1;
          ram_waddr   = slot_r;
          ram_wdata   = '0;
          res_act_nxt = tirt_pkg::ACT_NONE;
          res_xid_nxt = '0;
          res_dst_nxt = '0;
          if (live_r != '0) begin
            live_nxt = live_r - 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {(tirt_pkg::OUT_TDATA_W - XW - KW)'(0), res_dst_r, res_xid_r};
          out_tuser_nxt = res_act_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      period_nxt = cfg_data;
      ticks_nxt  = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      walk_cnt_r  <= '0;
      chk_v_r     <= 1'b0;
      next_id_r   <= '0;
      next_slot_r <= '0;
      live_r      <= '0;
      ticks_r     <= tirt_pkg::PERIOD_RESET;
      period_r    <= tirt_pkg::PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      next_id_r   <= next_id_nxt;
      next_slot_r <= next_slot_nxt;
      live_r      <= live_nxt;
      ticks_r     <= ticks_nxt;
      period_r    <= period_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_addr_r   <= chk_addr_nxt;
    op_r         <= op_nxt;
    barrier_r    <= barrier_nxt;
    ctlr_r       <= ctlr_nxt;
    xid_r        <= xid_nxt;
    alloc_ctlr_r <= alloc_ctlr_nxt;
    slot_r       <= slot_nxt;
    hit_r        <= hit_nxt;
    mine_r       <= mine_nxt;
    res_act_r    <= res_act_nxt;
    res_xid_r    <= res_xid_nxt;
    res_dst_r    <= res_dst_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

`ifndef SYNTHESIS
  a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(TABLE_DEPTH))
    else $error("live entry count above table depth");

  a_live_step: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r == $past(live_r)) || (live_r == $past(live_r) + 1'b1) ||
    (live_r == $past(live_r) - 1'b1))
    else $error("live entry count moved by more than one");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("new transaction accepted while one is in progress");
`endif

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the transaction id remap table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tirt_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int LONG_HOLD = 600;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    bit [OP_W-1:0]   opcode;
    bit              echo;
    bit              barrier_reply;
    bit [CTLR_W-1:0] ctlr;
    bit [XID_W-1:0]  xid;
  } remap_req_t;

  typedef struct packed {
    bit [ACT_W-1:0]  action;
    bit [XID_W-1:0]  xid;
    bit [CTLR_W-1:0] dest;
  } remap_resp_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  transaction_id_remap_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tuser(in_tuser), .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted copy of the block's state
  bit              tbl_valid[DEPTH];
  bit [XID_W-1:0]  tbl_id[DEPTH];
  bit [XID_W-1:0]  tbl_orig[DEPTH];
  bit [CTLR_W-1:0] tbl_ctlr[DEPTH];
  bit              tbl_from_ctlr[DEPTH];
  bit [XID_W-1:0]  next_xid;
  int unsigned     live_entries;
  bit [PERIOD_W-1:0] period_reg;
  bit [PERIOD_W-1:0] ticks_left;

  remap_resp_t pending_resp[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit sender_pauses = 1'b1;
  int unsigned burst_left = 0;
  logic hold_toggle = 1'b0;

  function automatic bit claim_slot(input bit from_ctlr, input bit [CTLR_W-1:0] ctlr,
                                    input bit [XID_W-1:0] orig);
    int unsigned s;
    s = next_xid % DEPTH;
    if (tbl_valid[s]) return 1'b0;
    tbl_valid[s] = 1'b1;
    tbl_id[s] = next_xid;
    tbl_orig[s] = orig;
    tbl_ctlr[s] = ctlr;
    tbl_from_ctlr[s] = from_ctlr;
    live_entries++;
    next_xid++;
    return 1'b1;
  endfunction

  function automatic void drop_entry(input int unsigned s);
    if (tbl_valid[s]) begin
      tbl_valid[s] = 1'b0;
      if (live_entries > 0) live_entries--;
    end
  endfunction

  function automatic remap_resp_t predict_remap(input remap_req_t r);
    remap_resp_t res;
    int unsigned s;
    bit [XID_W-1:0] mine;
    bit [XID_W-1:0] age;
    res.action = ACT_NONE;
    res.xid = '0;
    res.dest = '0;
    case (r.opcode)
      OP_CTLR: begin
        if (r.ctlr < CTLR_COUNT) begin
          if (r.echo) begin
            res.action = ACT_ECHO;
            res.xid = r.xid;
            res.dest = r.ctlr;
          end else begin
            res.xid = next_xid;
            if (claim_slot(1'b1, r.ctlr, r.xid)) begin
              res.action = ACT_TO_SWITCH;
            end else begin
              res.action = ACT_FULL;
              res.dest = r.ctlr;
            end
          end
        end
      end
      OP_SWITCH: begin
        if (r.echo) begin
          res.action = ACT_ECHO;
          res.xid = r.xid;
        end else begin
          s = r.xid % DEPTH;
          if (tbl_valid[s] && tbl_id[s] == r.xid) begin
            if (r.barrier_reply) begin
              // a barrier reply flushes everything older than the matched entry
              mine = next_xid - tbl_id[s];
              for (int t = 0; t < DEPTH; t++) begin
                age = next_xid - tbl_id[t];
                if (tbl_valid[t] && age > mine) drop_entry(t);
              end
            end
            if (tbl_from_ctlr[s]) begin
              res.action = ACT_TO_CTLR;
              res.xid = tbl_orig[s];
              res.dest = tbl_ctlr[s];
            end else begin
              drop_entry(s);
            end
          end
        end
      end
      OP_TICK: begin
        if (period_reg != 0) begin
          if (ticks_left <= 1) begin
            ticks_left = period_reg;
            if (live_entries > 0) begin
              res.xid = next_xid;
              res.action = claim_slot(1'b0, '0, '0) ? ACT_BARRIER : ACT_FULL;
            end
          end else begin
            ticks_left--;
          end
        end
      end
      default: begin
        if (r.ctlr < CTLR_COUNT)
          for (int t = 0; t < DEPTH; t++)
            if (tbl_valid[t] && tbl_from_ctlr[t] && tbl_ctlr[t] == r.ctlr) drop_entry(t);
      end
    endcase
    return res;
  endfunction

  function automatic remap_req_t mk_req(input bit [OP_W-1:0] op, input bit echo,
                                        input bit bar, input bit [CTLR_W-1:0] ctlr,
                                        input bit [XID_W-1:0] xid);
    remap_req_t r;
    r.opcode = op;
    r.echo = echo;
    r.barrier_reply = bar;
    r.ctlr = ctlr;
    r.xid = xid;
    return r;
  endfunction

  // live entry from a random starting slot, -1 when none
  function automatic int find_entry(input bit want_barrier);
    int unsigned start;
    int unsigned t;
    start = $urandom_range(0, DEPTH - 1);
    for (int k = 0; k < DEPTH; k++) begin
      t = (start + k) % DEPTH;
      if (tbl_valid[t] && (!want_barrier || !tbl_from_ctlr[t])) return t;
    end
    return -1;
  endfunction

  function automatic remap_req_t pick_item();
    remap_req_t r;
    int unsigned roll;
    int s;
    r = mk_req($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
               $urandom_range(0, 7), $urandom());
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      r.opcode = OP_CTLR;
      r.echo = 1'b0;
    end else if (roll < 34) begin
      r.opcode = OP_CTLR;
      r.echo = 1'b1;
    end else if (roll < 36) begin
      r.opcode = OP_SWITCH;
      r.echo = 1'b1;
    end else if (roll < 68) begin
      // replies to live entries, barriers preferred for the flush
      s = find_entry(roll < 48);
      r.opcode = OP_SWITCH;
      r.echo = 1'b0;
      if (s >= 0) begin
        r.xid = tbl_id[s];
        r.barrier_reply = tbl_from_ctlr[s] ? ($urandom_range(0, 4) == 0)
                                           : ($urandom_range(0, 9) != 0);
      end else if (roll < 48) begin
        r.opcode = OP_TICK;
      end else begin
        r.xid = next_xid + $urandom_range(0, 2 * DEPTH);
      end
    end else if (roll < 90) begin
      r.opcode = OP_TICK;
    end else if (roll < 94) begin
      r.opcode = OP_DISC;
    end
    return r;
  endfunction

  task automatic clear_model();
    for (int t = 0; t < DEPTH; t++) tbl_valid[t] = 1'b0;
    next_xid = '0;
    live_entries = 0;
    period_reg = PERIOD_RESET;
    ticks_left = PERIOD_RESET;
  endtask

  task automatic send_item(input remap_req_t r);
    int unsigned gap;
    in_tuser <= {r.barrier_reply, r.echo, r.opcode};
    in_tdata <= {{(IN_TDATA_W - XID_W - CTLR_W){1'b0}}, r.xid, r.ctlr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_resp.push_back(predict_remap(r));
    gap = 0;
    if (sender_pauses) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic write_period(input bit [PERIOD_W-1:0] p);
    cfg_data <= p;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_reg = p;
    ticks_left = p;
  endtask

  task automatic test_directed();
    send_item(mk_req(OP_CTLR, 1'b1, 1'b0, 3'd0, 32'h0000_0000));
    send_item(mk_req(OP_CTLR, 1'b1, 1'b0, 3'd7, 32'hffff_ffff));
    send_item(mk_req(OP_SWITCH, 1'b1, 1'b0, 3'd5, 32'ha5a5_a5a5));
    send_item(mk_req(OP_TICK, 1'b0, 1'b0, 3'd0, 32'h0));
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b0, 3'd0, 32'h0));      // empty table, no match
    send_item(mk_req(OP_CTLR, 1'b0, 1'b0, 3'd0, 32'hffff_ffff));
    send_item(mk_req(OP_CTLR, 1'b0, 1'b0, 3'd7, 32'h0));
    send_item(mk_req(OP_CTLR, 1'b0, 1'b1, 3'd3, 32'h1234_5678));
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b0, 3'd2, 32'd1));
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b0, 3'd0, 32'd1 + DEPTH)); // slot hit, id differs
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b1, 3'd0, 32'd0));
    repeat (4) send_item(mk_req(OP_TICK, 1'b1, 1'b1, 3'd6, 32'hffff_ffff));
    send_item(mk_req(OP_CTLR, 1'b0, 1'b0, 3'd2, 32'h8000_0001));
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b1, 3'd0, 32'd3));      // barrier reply
    send_item(mk_req(OP_DISC, 1'b0, 1'b0, 3'd2, 32'h0));
    send_item(mk_req(OP_DISC, 1'b1, 1'b1, 3'd7, 32'hffff_ffff));
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b0, 3'd0, 32'd4));
    drain();
    write_period(16'd1);
    send_item(mk_req(OP_TICK, 1'b0, 1'b0, 3'd0, 32'h0));        // expiry with empty table
    send_item(mk_req(OP_CTLR, 1'b0, 1'b0, 3'd1, 32'h0000_ffff));
    send_item(mk_req(OP_TICK, 1'b0, 1'b0, 3'd0, 32'h0));
    send_item(mk_req(OP_SWITCH, 1'b0, 1'b1, 3'd0, 32'd6));
    drain();
    write_period(16'd0);
    send_item(mk_req(OP_TICK, 1'b0, 1'b0, 3'd0, 32'h0));        // ticks disabled
  endtask

  task automatic test_table_full();
    drain();
    for (int i = 0; i < 262; i++) begin
      send_item(mk_req(OP_CTLR, 1'b0, 1'b0, $urandom_range(0, 7), $urandom()));
      if (i == 120) send_item(mk_req(OP_SWITCH, 1'b0, 1'b0, 3'd0, next_xid - 40));
    end
    send_item(mk_req(OP_CTLR, 1'b1, 1'b0, 3'd4, $urandom()));
    drain();
    write_period(16'd1);
    send_item(mk_req(OP_TICK, 1'b0, 1'b0, 3'd0, 32'h0));        // barrier refused, slot taken
    for (int c = 0; c < CTLR_COUNT; c++)
      send_item(mk_req(OP_DISC, 1'b0, 1'b0, c, $urandom()));
  endtask

  task automatic test_random_traffic(input bit [PERIOD_W-1:0] p, input int count,
                                     input bit pauses);
    drain();
    write_period(p);
    sender_pauses = pauses;
    for (int i = 0; i < count; i++) send_item(pick_item());
    sender_pauses = 1'b1;
  endtask

  // the sink stops for a long while so the block backs up onto its input
  task automatic test_backpressure();
    drain();
    write_period($urandom_range(2, 6));
    sender_pauses = 1'b0;
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 100; i++) send_item(pick_item());
    sender_pauses = 1'b1;
  endtask

  always @(posedge clk) begin : sink_pattern
    static logic hold_seen = 1'b0;
    static int unsigned hold_left = 0;
    static int unsigned mode_left = 0;
    static rx_mode_e rx_mode = RX_OPEN;
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_HALF:   out_tready <= $urandom_range(0, 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    remap_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_resp.size() == 0) begin
        $error("unexpected result transaction: action %0d, out_xid %h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        want = pending_resp.pop_front();
        if (out_tuser[ACT_W-1:0] !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_tuser[ACT_W-1:0]);
          fail_count++;
        end
        if (out_tdata[XID_W-1:0] !== want.xid) begin
          $error("out_xid: expected %h, got %h", want.xid, out_tdata[XID_W-1:0]);
          fail_count++;
        end
        if (out_tdata[XID_W+CTLR_W-1:XID_W] !== want.dest) begin
          $error("dest_ctlr: expected %0d, got %0d", want.dest,
                 out_tdata[XID_W+CTLR_W-1:XID_W]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random_traffic(16'd2, 300, 1'b1);
    test_random_traffic(16'hffff, 200, 1'b0);
    test_random_traffic($urandom_range(3, 12), 300, 1'b1);
    test_random_traffic(16'd1, 200, 1'b1);
    test_backpressure();
    test_random_traffic(16'd0, 100, 1'b1);
    drain();
    repeat (DEPTH + 16) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tirt_pkg.sv
rtl/tirt_ram.sv
rtl/tirt_xid_mod.sv
rtl/transaction_id_remap_table.sv
sim/testbench.sv
